@@ sv/fltpm_pkg.sv @@
// shared constants for the four-level page table manager
package fltpm_pkg;
  localparam int TableFramesDef = 16;
  localparam int EntriesPerTable = 512;
  localparam int IdxW = 9;

  localparam logic [1:0] ActMap = 2'd0;
  localparam logic [1:0] ActQuery = 2'd1;
  localparam logic [1:0] ActUnmap = 2'd2;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StInval = 3'd1;
  localparam logic [2:0] StExists = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StNoMem = 3'd4;

  localparam logic [1:0] CfgRoot = 2'd0;
  localparam logic [1:0] CfgAllocFirst = 2'd1;
  localparam logic [1:0] CfgAllocEnd = 2'd2;

  localparam logic [63:0] PteP = 64'h1;
  localparam logic [63:0] PtePs = 64'h80;
  localparam logic [63:0] PteW = 64'h2;
  localparam logic [63:0] AddrField = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] FlagAllowed = 64'h8000_0000_0000_011E;
endpackage

@@ sv/fltpm_ram.sv @@
// generic single-port ram with registered read
module fltpm_ram #(
  parameter int Width = 64,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ sv/four_level_page_table_manager.sv @@
// top level of the four-level page table manager
// The page tables live in one single-port ram of TableFrames frames of 512
// 64-bit entries. After reset a clearing pass writes zero to every entry,
// one a cycle, while no item is accepted. Each item walks pml4, pdpt, pd
// and pt with one ram read per level, through the read, wait and decide
// states. An item that fails its address or root checks, or has an unknown
// action, goes from read to done without a ram read, and a walk that stops
// at an upper level ends early. A map that creates a table also zeroes its
// 512 entries, one a cycle, and then links it. The ram port is the limit.
// The result sits in an output register; a new item is accepted once the
// previous result has been taken. Register writes are taken only while the
// block is idle.
module four_level_page_table_manager #(
  parameter int TableFrames = fltpm_pkg::TableFramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] vaddr_i,
  input  logic [63:0] paddr_i,
  input  logic [63:0] flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [51:0] out_paddr_o,
  output logic [63:0] out_flags_o,
  output logic        tlb_invalidate_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  localparam int FrW = (TableFrames > 1) ? $clog2(TableFrames) : 1;
  localparam int AddrW = FrW + fltpm_pkg::IdxW;
  localparam int Depth = TableFrames * fltpm_pkg::EntriesPerTable;
  // counters hold frame numbers up to 31 and TableFrames itself
  localparam int CntW = (FrW + 1 > 5) ? FrW + 1 : 5;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_WAIT, S_DECIDE, S_ZERO, S_LINK, S_DONE
  } state_e;

  state_e state_q;
  logic [AddrW-1:0] clr_q;
  logic [1:0]  act_q;
  logic [63:0] va_q, pa_q, fl_q;
  logic [1:0]  lvl_q;      // 0 pml4 .. 3 pt
  logic [FrW-1:0] frame_q; // table being read
  logic [FrW-1:0] nf_frame_q;
  logic [3:0]  root_q;
  logic [4:0]  aend_q;
  logic [CntW-1:0] next_free_q;

  // ram port
  logic             we;
  logic [AddrW-1:0] addr;
  logic [63:0]      wdata, rdata;

  fltpm_ram #(.Width(64), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // index of the current level
  logic [8:0] idx;
  always_comb begin
    unique case (lvl_q)
      2'd0: idx = va_q[47:39];
      2'd1: idx = va_q[38:30];
      2'd2: idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  // entry frame number, or out of store
  logic [39:0] e_fr;
  logic        e_out;
  assign e_fr  = rdata[51:12];
  assign e_out = (e_fr >= 40'(TableFrames));

  // request checks
  logic va_ok, pa_ok, root_ok, alloc_ok;
  assign va_ok = (va_q[47] ? (va_q[63:48] == 16'hFFFF) : (va_q[63:48] == 16'h0))
                 && (va_q[11:0] == 12'h0);
  assign pa_ok = (pa_q[11:0] == 12'h0);
  assign root_ok = ({28'd0, root_q} < 32'(TableFrames));
  assign alloc_ok = (next_free_q < CntW'(aend_q)) && (next_free_q < CntW'(TableFrames));

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_o;
  assign cfg_ready_o = (state_q == S_IDLE);

  always_comb begin
    we = 1'b0;
    addr = {frame_q, idx};
    wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        addr = clr_q;
      end
      S_ZERO: begin
        we = 1'b1;
        addr = {nf_frame_q, clr_q[8:0]};
      end
      S_LINK: begin
        we = 1'b1;
        wdata = ({{(64-FrW){1'b0}}, nf_frame_q} << 12) | fltpm_pkg::PteP
                | fltpm_pkg::PteW;
      end
      S_DECIDE: begin
        if (lvl_q == 2'd3 && rdata[0]) begin
          if (act_q == fltpm_pkg::ActUnmap) begin
            we = 1'b1;
          end
        end else if (lvl_q == 2'd3 && act_q == fltpm_pkg::ActMap) begin
          we = 1'b1;
          wdata = (pa_q & fltpm_pkg::AddrField) | fltpm_pkg::PteP
                  | (fl_q & fltpm_pkg::FlagAllowed);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      out_valid_o <= 1'b0;
      root_q <= '0;
      aend_q <= 5'd16;
      next_free_q <= CntW'(1);
      act_q <= '0; va_q <= '0; pa_q <= '0; fl_q <= '0;
      lvl_q <= '0; frame_q <= '0; nf_frame_q <= '0;
      status_o <= '0; out_paddr_o <= '0; out_flags_o <= '0;
      tlb_invalidate_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fltpm_pkg::CfgRoot: root_q <= cfg_data_i[3:0];
          // writing the allocator base restarts the allocator there
          fltpm_pkg::CfgAllocFirst: next_free_q <= CntW'(cfg_data_i);
          fltpm_pkg::CfgAllocEnd: aend_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(Depth - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            act_q <= action_i;
            va_q <= vaddr_i;
            pa_q <= paddr_i;
            fl_q <= flags_i;
            lvl_q <= 2'd0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // checks before the walk
          status_o <= fltpm_pkg::StInval;
          out_paddr_o <= '0;
          out_flags_o <= '0;
          tlb_invalidate_o <= 1'b0;
          if (lvl_q == 2'd0) begin
            if (act_q == fltpm_pkg::ActMap || act_q == fltpm_pkg::ActQuery
                || act_q == fltpm_pkg::ActUnmap) begin
              if (!va_ok || (act_q == fltpm_pkg::ActMap && !pa_ok)
                  || !root_ok) begin
                state_q <= S_DONE;
              end else begin
                frame_q <= FrW'(root_q);
                state_q <= S_WAIT;
              end
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_DECIDE;
        S_DECIDE: begin
          state_q <= S_DONE;
          if (lvl_q == 2'd3) begin
            if (rdata[0]) begin
              if (act_q == fltpm_pkg::ActMap) begin
                status_o <= fltpm_pkg::StExists;
              end else if (act_q == fltpm_pkg::ActQuery) begin
                status_o <= fltpm_pkg::StOk;
                out_paddr_o <= rdata[51:0] & fltpm_pkg::AddrField[51:0];
                out_flags_o <= rdata & ~fltpm_pkg::AddrField;
              end else begin
                status_o <= fltpm_pkg::StOk;
                tlb_invalidate_o <= 1'b1;
              end
            end else begin
              status_o <= (act_q == fltpm_pkg::ActMap) ? fltpm_pkg::StOk
                                                       : fltpm_pkg::StNotFound;
            end
          end else if (rdata[0]) begin
            if (rdata[7]) begin
              status_o <= (act_q == fltpm_pkg::ActMap) ? fltpm_pkg::StExists
                                                       : fltpm_pkg::StNotFound;
            end else if (e_out) begin
              status_o <= fltpm_pkg::StInval;
            end else begin
              frame_q <= e_fr[FrW-1:0];
              lvl_q <= lvl_q + 1'b1;
              state_q <= S_READ;
            end
          end else if (act_q != fltpm_pkg::ActMap) begin
            status_o <= fltpm_pkg::StNotFound;
          end else if (!alloc_ok) begin
            status_o <= fltpm_pkg::StNoMem;
          end else begin
            // allocate a fresh table and zero it
            nf_frame_q <= next_free_q[FrW-1:0];
            next_free_q <= next_free_q + 1'b1;
            clr_q <= '0;
            state_q <= S_ZERO;
          end
        end
        S_ZERO: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[8:0] == 9'h1FF) begin
            state_q <= S_LINK;
          end
        end
        S_LINK: begin
          frame_q <= nf_frame_q;
          lvl_q <= lvl_q + 1'b1;
          state_q <= S_READ;
        end
        S_DONE: begin
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/fltpm_checker.sv @@
// port-level checks for the page table manager
module fltpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [51:0] out_paddr_o,
  input logic        tlb_invalidate_o
);
  a_no_accept_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item accepted with result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_inv_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tlb_invalidate_o |-> status_o == fltpm_pkg::StOk)
    else $error("invalidate without success");
  a_pa_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != fltpm_pkg::StOk |-> out_paddr_o == '0)
    else $error("address on failure");
endmodule

bind four_level_page_table_manager fltpm_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .status_o(status_o),
  .out_paddr_o(out_paddr_o), .tlb_invalidate_o(tlb_invalidate_o)
);

@@ tb/sv/tb_four_level_page_table_manager.sv @@
// self-checking bench for the four-level page table manager: shadow tables predict every reply
module tb_four_level_page_table_manager;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frames = fltpm_pkg::TableFramesDef;
  localparam int Entries = fltpm_pkg::EntriesPerTable;
  localparam logic [1:0] ActUnknown = 2'd3;
  localparam longint unsigned CycleLimit = 3_000_000;
  localparam int DrainCycles = 700;  // one table zeroing plus a walk

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] paddr;
    logic [63:0] flags;
    logic        inval;
  } reply_t;

  // shadow copy of the tables, the allocator and the registers
  class pt_shadow;
    logic [63:0] mem [Frames*Entries];
    int unsigned next_free, root, last;
    reply_t      pending [$];
    int          errors;

    function new();
      foreach (mem[i]) mem[i] = '0;
      root = 0; last = 16; next_free = 1; errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [4:0] data);
      case (index)
        fltpm_pkg::CfgRoot: root = data[3:0];
        fltpm_pkg::CfgAllocFirst: next_free = data;
        fltpm_pkg::CfgAllocEnd: last = data;
        default: ;
      endcase
    endfunction

    function bit canonical_aligned(logic [63:0] va);
      logic [15:0] top;
      top = va[63:48];
      return (va[47] ? top == 16'hFFFF : top == 16'h0) && va[11:0] == 12'h0;
    endfunction

    function int unsigned frame_of(logic [63:0] e);
      logic [63:0] f;
      f = (e & fltpm_pkg::AddrField) >> 12;
      return (f < Frames) ? int'(f) : Frames;
    endfunction

    // follow one level, creating the next table if it is missing
    function logic [2:0] descend_alloc(int unsigned frame, logic [8:0] idx,
                                       output int unsigned nxt);
      logic [63:0] e;
      int unsigned nf;
      e = mem[frame*Entries + idx];
      nxt = frame;
      if (e & fltpm_pkg::PteP) begin
        if (e & fltpm_pkg::PtePs) return fltpm_pkg::StExists;
        if (frame_of(e) >= Frames) return fltpm_pkg::StInval;
        nxt = frame_of(e);
        return fltpm_pkg::StOk;
      end
      if (next_free >= last || next_free >= Frames) return fltpm_pkg::StNoMem;
      nf = next_free;
      next_free++;
      for (int i = 0; i < Entries; i++) mem[nf*Entries + i] = '0;
      mem[frame*Entries + idx] = (64'(nf) << 12) | fltpm_pkg::PteP | fltpm_pkg::PteW;
      nxt = nf;
      return fltpm_pkg::StOk;
    endfunction

    function void note_request(logic [1:0] act, logic [63:0] va, logic [63:0] pa,
                               logic [63:0] fl);
      reply_t r;
      int unsigned f;
      logic [2:0] st;
      logic [63:0] e;
      int unsigned leaf;
      r = '0;
      st = fltpm_pkg::StInval;
      f = root;
      if (act == fltpm_pkg::ActMap) begin
        if (canonical_aligned(va) && pa[11:0] == 12'h0) begin
          if (f >= Frames) st = fltpm_pkg::StInval;
          else begin
            st = descend_alloc(f, va[47:39], f);
            if (st == fltpm_pkg::StOk) st = descend_alloc(f, va[38:30], f);
            if (st == fltpm_pkg::StOk) st = descend_alloc(f, va[29:21], f);
            if (st == fltpm_pkg::StOk) begin
              leaf = f*Entries + va[20:12];
              if (mem[leaf] & fltpm_pkg::PteP) st = fltpm_pkg::StExists;
              else mem[leaf] = (pa & fltpm_pkg::AddrField) | fltpm_pkg::PteP
                               | (fl & fltpm_pkg::FlagAllowed);
            end
          end
        end
      end else if (act == fltpm_pkg::ActQuery || act == fltpm_pkg::ActUnmap) begin
        if (canonical_aligned(va)) begin
          st = fltpm_pkg::StOk;
          if (f >= Frames) st = fltpm_pkg::StInval;
          for (int lv = 0; lv < 3 && st == fltpm_pkg::StOk; lv++) begin
            e = mem[f*Entries + ((va >> (39 - 9*lv)) & 64'h1FF)];
            if (!(e & fltpm_pkg::PteP) || (e & fltpm_pkg::PtePs)) st = fltpm_pkg::StNotFound;
            else if (frame_of(e) >= Frames) st = fltpm_pkg::StInval;
            else f = frame_of(e);
          end
          if (st == fltpm_pkg::StOk) begin
            leaf = f*Entries + va[20:12];
            if (!(mem[leaf] & fltpm_pkg::PteP)) st = fltpm_pkg::StNotFound;
            else if (act == fltpm_pkg::ActQuery) begin
              r.paddr = mem[leaf][51:0] & fltpm_pkg::AddrField[51:0];
              r.flags = mem[leaf] & ~fltpm_pkg::AddrField;
            end else begin
              mem[leaf] = '0;
              r.inval = 1'b1;
            end
          end
        end
      end
      r.status = st;
      pending.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.paddr !== want.paddr) begin
        $display("%0t: paddr expected %h actual %h", $time, want.paddr, got.paddr);
        errors++;
      end
      if (got.flags !== want.flags) begin
        $display("%0t: flags expected %h actual %h", $time, want.flags, got.flags);
        errors++;
      end
      if (got.inval !== want.inval) begin
        $display("%0t: tlb invalidate expected %0d actual %0d", $time, want.inval, got.inval);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = '0;
  logic [63:0] vaddr_i = '0;
  logic [63:0] paddr_i = '0;
  logic [63:0] flags_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [51:0] out_paddr_o;
  logic [63:0] out_flags_o;
  logic        tlb_invalidate_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  pt_shadow        shadow = new();
  longint unsigned cycles = 0;
  int              accepted = 0;

  four_level_page_table_manager DUT (.*);

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // predict on every accepted request, check every accepted reply
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      shadow.note_request(action_i, vaddr_i, paddr_i, flags_i);
      accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i)
      shadow.check_reply('{status_o, out_paddr_o, out_flags_o, tlb_invalidate_o});
  end

  // receiver: one long hold-off once traffic flows, then random stall patterns
  initial begin
    int mode, len;
    @(posedge clk_i);
    out_ready_i <= 1'b1;
    wait (accepted >= 30);
    @(posedge clk_i);
    out_ready_i <= 1'b0;
    repeat (1500) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(1, 60);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;                        // no stalls
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= $urandom_range(0, 1);
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  int burst_left = 0;

  // offer one request and hold it until taken; gaps fall between bursts
  task automatic send_request(logic [1:0] act, logic [63:0] va, logic [63:0] pa,
                              logic [63:0] fl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i <= act;
    vaddr_i <= va;
    paddr_i <= pa;
    flags_i <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [4:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.write_reg(index, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // let every reply drain before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly canonical page address, indices drawn from a few values so tables get reused
  function automatic logic [63:0] pick_vaddr();
    logic [8:0]  idx [4];
    logic [63:0] va;
    foreach (idx[i]) begin
      case ($urandom_range(0, 5))
        0: idx[i] = 9'd0;
        1: idx[i] = 9'd1;
        2: idx[i] = 9'd511;
        3: idx[i] = 9'd256;
        4: idx[i] = 9'($urandom_range(0, 3));
        default: idx[i] = 9'($urandom);
      endcase
    end
    va = {16'h0, idx[0], idx[1], idx[2], idx[3], 12'h0};
    if (va[47]) va[63:48] = 16'hFFFF;
    case ($urandom_range(0, 19))
      0: va = {$urandom, $urandom};                  // raw noise
      1: va[11:0] = 12'($urandom_range(1, 4095));    // misaligned
      2: va[63:48] = ~va[63:48] ^ 16'($urandom);     // broken sign extension
      default: ;
    endcase
    return va;
  endfunction

  task automatic random_requests(int count);
    logic [63:0] pa, va;
    logic [1:0]  act;
    logic [63:0] recent [$];
    repeat (count) begin
      // reuse recent addresses so queries and unmaps hit
      if (recent.size() != 0 && $urandom_range(0, 1)) va = recent[$urandom_range(0, recent.size()-1)];
      else va = pick_vaddr();
      recent.push_back(va);
      if (recent.size() > 24) void'(recent.pop_front());
      pa = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0) pa = 64'($urandom_range(0, 31)) << 12;
      if ($urandom_range(0, 14) != 0) pa[11:0] = 12'h0;
      case ($urandom_range(0, 19))
        0: act = ActUnknown;
        1, 2, 3, 4, 5, 6, 7, 8: act = fltpm_pkg::ActMap;
        9, 10, 11, 12, 13, 14: act = fltpm_pkg::ActQuery;
        default: act = fltpm_pkg::ActUnmap;
      endcase
      send_request(act, va, pa, {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: basic lifecycle, address checks, extremes
    send_request(fltpm_pkg::ActMap, 64'h0000_0000_0040_1000, 64'h0000_0000_1234_5000, '1);
    send_request(fltpm_pkg::ActMap, 64'h0000_0000_0040_1000, 64'h0000_0000_0000_3000, '0);
    send_request(fltpm_pkg::ActQuery, 64'h0000_0000_0040_1000, '0, '0);
    send_request(fltpm_pkg::ActUnmap, 64'h0000_0000_0040_1000, '0, '0);
    send_request(fltpm_pkg::ActQuery, 64'h0000_0000_0040_1000, '0, '0);
    send_request(fltpm_pkg::ActUnmap, 64'h0000_0000_0040_1000, '0, '0);
    send_request(fltpm_pkg::ActUnmap, 64'h0000_5555_0000_0000, '0, '0);
    send_request(ActUnknown, 64'h0000_0000_0040_1000, '0, '0);
    send_request(fltpm_pkg::ActMap, 64'h0000_8000_0000_0000, '0, '0);    // non-canonical
    send_request(fltpm_pkg::ActQuery, 64'hFFFF_0000_0000_0000, '0, '0);  // non-canonical
    send_request(fltpm_pkg::ActMap, 64'h0000_0000_0000_0800, '0, '0);    // misaligned va
    send_request(fltpm_pkg::ActMap, 64'h0000_0000_0000_2000, 64'h1001, '0);  // misaligned pa
    send_request(fltpm_pkg::ActMap, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000, '1);
    send_request(fltpm_pkg::ActQuery, 64'hFFFF_FFFF_FFFF_F000, '1, '1);
    send_request(fltpm_pkg::ActMap, 64'h0000_7FFF_FFFF_F000, 64'h0, 64'h8000_0000_0000_0000);
    send_request(fltpm_pkg::ActQuery, 64'h0000_7FFF_FFFF_F000, '0, '0);
    send_request(fltpm_pkg::ActMap, 64'h0, 64'h0000_0000_0000_5000, 64'h0000_0000_0000_0080);
    send_request(fltpm_pkg::ActQuery, 64'h0, '0, '0);
    send_request(fltpm_pkg::ActUnmap, 64'hFFFF_FFFF_FFFF_F000, '0, '0);
    send_request(fltpm_pkg::ActQuery, 64'hFFFF_FFFF_FFFF_F000, '0, '0);
    random_requests(120);
    settle();

    // tight allocator: runs out of frames part way through walks
    write_reg(fltpm_pkg::CfgAllocEnd, 5'd4);
    write_reg(fltpm_pkg::CfgAllocFirst, 5'd2);
    write_reg(fltpm_pkg::CfgRoot, 4'd0);
    random_requests(120);
    settle();

    // exhausted allocator, first register at its top
    write_reg(fltpm_pkg::CfgAllocFirst, 5'd16);
    write_reg(fltpm_pkg::CfgAllocEnd, 5'd16);
    random_requests(80);
    settle();

    // new root in a fresh area, allocator from zero can hand out the root itself
    write_reg(fltpm_pkg::CfgRoot, 4'd15);
    write_reg(fltpm_pkg::CfgAllocFirst, 5'd0);
    write_reg(fltpm_pkg::CfgAllocEnd, 5'd16);
    random_requests(160);
    settle();

    // empty range and root pointing into lower-level tables
    write_reg(fltpm_pkg::CfgAllocEnd, 5'd0);
    write_reg(fltpm_pkg::CfgRoot, 4'($urandom_range(1, 14)));
    random_requests(80);
    settle();

    // random settings
    repeat (3) begin
      write_reg(fltpm_pkg::CfgRoot, 4'($urandom));
      write_reg(fltpm_pkg::CfgAllocFirst, 5'($urandom_range(0, 16)));
      write_reg(fltpm_pkg::CfgAllocEnd, 5'($urandom_range(0, 16)));
      random_requests(80);
      settle();
    end

    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
